// ----- design/path_name_validator_assert.svh -----
// assertion macros used by the path name validator top level
`ifndef PATH_NAME_VALIDATOR_ASSERT_SVH
`define PATH_NAME_VALIDATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PNV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define PNV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/pnv_pkg.sv -----
// shared types and constants for the path name validator
package pnv_pkg;

  localparam int COUNTER_BITS_DEF = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam int LIMIT_W = 16;

  localparam logic [LIMIT_W-1:0] MAX_PATH_LEN_RST = 16'd259;
  localparam logic [LIMIT_W-1:0] MAX_COMP_LEN_RST = 16'd255;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POSIX_CHECK   = 8'd0,
    CFG_LEADING_CHECK = 8'd1,
    CFG_MAX_PATH_LEN  = 8'd2,
    CFG_MAX_COMP_LEN  = 8'd3
  } pnv_cfg_idx_t;

  // characters of interest
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DIG1   = 8'h31;
  localparam logic [7:0] CH_DIG9   = 8'h39;

  // reserved device names, upper case, packed low-aligned
  localparam logic [31:0] DEV_CON = 32'h00434F4E;
  localparam logic [31:0] DEV_PRN = 32'h0050524E;
  localparam logic [31:0] DEV_AUX = 32'h00415558;
  localparam logic [31:0] DEV_NUL = 32'h004E554C;
  localparam logic [23:0] DEV_COM = 24'h434F4D;
  localparam logic [23:0] DEV_LPT = 24'h4C5054;

  // per-byte classification
  typedef struct packed {
    logic       is_sep;
    logic       is_control;
    logic       is_bad;
    logic       is_portable;
    logic       is_hyphen;
    logic [7:0] upper;
  } pnv_class_t;

  // sticky per-name flags
  typedef struct packed {
    logic hyphen;
    logic control;
    logic badchar;
    logic reserved;
    logic trailing;
    logic nonport;
    logic complong;
    logic nameovf;
    logic compovf;
  } pnv_flags_t;

endpackage

// ----- design/path_name_validator.sv -----
// top level of the path name validator: input register, checks, result register
// Accepts one transaction per clock unless stalled: byte transactions (op 0) update running
// counters and sticky error flags, and an end transaction (op 1) loads its result from the input
// register into the result register, where it is presented, and clears the per-name state.
// The rate is set by the single pass of byte checks and counter updates between the input
// register and the result register; an end transaction waits in the input register only while
// the result register is full and stalled.
module path_name_validator #(
  parameter int COUNTER_BITS = pnv_pkg::COUNTER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_op,
  input  logic [7:0]                     in_char_byte,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_name_valid,
  output logic                           out_err_empty,
  output logic                           out_err_leading_hyphen,
  output logic                           out_err_control,
  output logic                           out_err_bad_char,
  output logic                           out_err_reserved,
  output logic                           out_err_trailing,
  output logic                           out_err_nonportable,
  output logic                           out_err_component_long,
  output logic                           out_err_path_long,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pnv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pnv_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pnv_pkg::*;

  localparam int CMP_W = (COUNTER_BITS > LIMIT_W) ? COUNTER_BITS : LIMIT_W;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

  // configuration registers
  logic               posix_r;
  logic               leading_r;
  logic [LIMIT_W-1:0] max_path_r;
  logic [LIMIT_W-1:0] max_comp_r;

  // input register
  logic       in_valid_r;
  logic       in_op_r;
  logic [7:0] in_byte_r;

  // per-name state
  logic [COUNTER_BITS-1:0] name_len_r, name_len_nxt;
  logic [COUNTER_BITS-1:0] comp_len_r, comp_len_nxt;
  logic [7:0]              last_r, last_nxt;
  logic [31:0]             prefix_r, prefix_nxt;
  pnv_flags_t              flags_r, flags_nxt;

  // result register
  logic       out_valid_r;
  logic [9:0] res_r, res_nxt;

  logic       out_free;
  logic       proc_fire;
  logic       in_fire;
  logic       out_fire;
  pnv_class_t cls;
  pnv_flags_t closed;
  logic       res3;
  logic       res4;
  logic       empty;
  logic       e_pl;
  logic [8:0] errs;

  pnv_byte_class u_class (
    .char_byte (in_byte_r),
    .cls       (cls)
  );

  // handshake
  assign cfg_ready = 1'b1;
  assign out_fire  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign proc_fire = in_valid_r && (!in_op_r || out_free);
  assign in_stall  = in_valid_r && !proc_fire;
  assign in_fire   = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      posix_r    <= 1'b0;
      leading_r  <= 1'b0;
      max_path_r <= MAX_PATH_LEN_RST;
      max_comp_r <= MAX_COMP_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POSIX_CHECK:   posix_r    <= cfg_data[0];
        CFG_LEADING_CHECK: leading_r  <= cfg_data[0];
        CFG_MAX_PATH_LEN:  max_path_r <= cfg_data;
        CFG_MAX_COMP_LEN:  max_comp_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (proc_fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_op_r   <= in_op;
      in_byte_r <= in_char_byte;
    end
  end

  // component close checks on the current state
  always_comb begin
    res3 = !flags_r.compovf && (comp_len_r == COUNTER_BITS'(3)) &&
           ((prefix_r == DEV_CON) || (prefix_r == DEV_PRN) ||
            (prefix_r == DEV_AUX) || (prefix_r == DEV_NUL));
    res4 = !flags_r.compovf && (comp_len_r == COUNTER_BITS'(4)) &&
           ((prefix_r[31:8] == DEV_COM) || (prefix_r[31:8] == DEV_LPT)) &&
           (prefix_r[7:0] >= CH_DIG1) && (prefix_r[7:0] <= CH_DIG9);
    closed = flags_r;
    closed.reserved = flags_r.reserved || res3 || res4;
    closed.trailing = flags_r.trailing ||
                      ((flags_r.compovf || (comp_len_r != '0)) &&
                       ((last_r == CH_DOT) || (last_r == CH_SPACE)));
    closed.complong = flags_r.complong || flags_r.compovf ||
                      (CMP_W'(comp_len_r) > CMP_W'(max_comp_r));
    closed.compovf  = 1'b0;
  end

  // result flags for an end transaction
  always_comb begin
    empty = (name_len_r == '0) && !flags_r.nameovf;
    e_pl  = flags_r.nameovf || (CMP_W'(name_len_r) > CMP_W'(max_path_r));
    errs  = {leading_r && empty, leading_r && closed.hyphen, closed.control,
             closed.badchar, closed.reserved, closed.trailing,
             posix_r && closed.nonport, posix_r && closed.complong, e_pl};
    res_nxt = {~|errs, errs};
  end

  // per-name state update
  always_comb begin
    name_len_nxt = name_len_r;
    comp_len_nxt = comp_len_r;
    last_nxt     = last_r;
    prefix_nxt   = prefix_r;
    flags_nxt    = flags_r;
    if (in_op_r) begin
      name_len_nxt = '0;
      comp_len_nxt = '0;
      last_nxt     = '0;
      prefix_nxt   = '0;
      flags_nxt    = '0;
    end else begin
      flags_nxt.hyphen  = flags_r.hyphen || (empty && cls.is_hyphen);
      flags_nxt.control = flags_r.control || cls.is_control;
      flags_nxt.badchar = flags_r.badchar || cls.is_bad;
      if (name_len_r == CNT_MAX) begin
        flags_nxt.nameovf = 1'b1;
      end else begin
        name_len_nxt = name_len_r + 1'b1;
      end
      if (cls.is_sep) begin
        flags_nxt.reserved = closed.reserved;
        flags_nxt.trailing = closed.trailing;
        flags_nxt.complong = closed.complong;
        flags_nxt.compovf  = 1'b0;
        comp_len_nxt       = '0;
        last_nxt           = '0;
        prefix_nxt         = '0;
      end else begin
        flags_nxt.nonport = flags_r.nonport || !cls.is_portable;
        if ((comp_len_r < COUNTER_BITS'(4)) && !flags_r.compovf) begin
          prefix_nxt = {prefix_r[23:0], cls.upper};
        end
        if (comp_len_r == CNT_MAX) begin
          flags_nxt.compovf = 1'b1;
        end else begin
          comp_len_nxt = comp_len_r + 1'b1;
        end
        last_nxt = in_byte_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_len_r <= '0;
      comp_len_r <= '0;
      last_r     <= '0;
      prefix_r   <= '0;
      flags_r    <= '0;
    end else if (proc_fire) begin
      name_len_r <= name_len_nxt;
      comp_len_r <= comp_len_nxt;
      last_r     <= last_nxt;
      prefix_r   <= prefix_nxt;
      flags_r    <= flags_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire && in_op_r) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && in_op_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_name_valid         = res_r[9];
  assign out_err_empty          = res_r[8];
  assign out_err_leading_hyphen = res_r[7];
  assign out_err_control        = res_r[6];
  assign out_err_bad_char       = res_r[5];
  assign out_err_reserved       = res_r[4];
  assign out_err_trailing       = res_r[3];
  assign out_err_nonportable    = res_r[2];
  assign out_err_component_long = res_r[1];
  assign out_err_path_long      = res_r[0];

  // checks
`include "path_name_validator_assert.svh"

  `PNV_ASSERT_NOW(a_valid_flag, out_valid_r, res_r[9] == ~|res_r[8:0], "name_valid disagrees with error flags")
  `PNV_ASSERT_NEXT(a_end_clears, proc_fire && in_op_r, (name_len_r == '0) && (comp_len_r == '0) && (flags_r == '0), "end transaction did not clear name state")
  `PNV_ASSERT_NEXT(a_byte_no_result, proc_fire && !in_op_r && out_fire, !out_valid_r, "byte transaction produced a result")
  `PNV_ASSERT_NOW(a_comp_within_name, !flags_r.nameovf, comp_len_r <= name_len_r, "component length exceeds name length")

endmodule

// ----- design/pnv_byte_class.sv -----
// byte classifier for the path name validator
module pnv_byte_class (
  input  logic [7:0]          char_byte,
  output pnv_pkg::pnv_class_t cls
);
  import pnv_pkg::*;

  logic is_lower;
  logic is_upper;
  logic is_digit;

  // letter and digit ranges
  assign is_lower = (char_byte >= 8'h61) && (char_byte <= 8'h7A);
  assign is_upper = (char_byte >= 8'h41) && (char_byte <= 8'h5A);
  assign is_digit = (char_byte >= 8'h30) && (char_byte <= 8'h39);

  // flag decode
  always_comb begin
    cls.is_sep      = (char_byte == CH_SLASH) || (char_byte == CH_BSLASH);
    cls.is_control  = (char_byte < CH_SPACE);
    cls.is_bad      = (char_byte == CH_LT) || (char_byte == CH_GT) ||
                      (char_byte == CH_QUOTE) || (char_byte == CH_PIPE) ||
                      (char_byte == CH_QMARK) || (char_byte == CH_STAR);
    cls.is_portable = is_lower || is_upper || is_digit || (char_byte == CH_DOT) ||
                      (char_byte == CH_UNDER) || (char_byte == CH_HYPHEN);
    cls.is_hyphen   = (char_byte == CH_HYPHEN);
    cls.upper       = is_lower ? (char_byte - 8'd32) : char_byte;
  end

endmodule
